FILE: rtl/fbs_pkg.sv
// Shared types, codes and constants of the fetch backoff scheduler.
`timescale 1ns / 1ps

package fbs_pkg;

    localparam int TimeW   = 32;
    localparam int PollW   = 27;
    localparam int StreakW = 3;
    localparam int StatusW = 11;
    localparam int JitterW = 16;
    localparam int ModeW   = 2;
    localparam int CmdW    = 2;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 32;
    localparam int InDataW  = 64;
    localparam int OutDataW = 64;

    // Item commands.
    localparam logic [CmdW-1:0] CMD_TICK    = 2'd0;
    localparam logic [CmdW-1:0] CMD_OUTCOME = 2'd1;
    localparam logic [CmdW-1:0] CMD_FORCE   = 2'd2;

    // Source modes; the fourth code behaves as plain polling.
    localparam logic [ModeW-1:0] MODE_AIR  = 2'd0;
    localparam logic [ModeW-1:0] MODE_HTTP = 2'd1;
    localparam logic [ModeW-1:0] MODE_POLL = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_SOURCE_MODE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_POLL        = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_HOLD_EN     = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_HOLD_UNTIL  = 2'd3;

    localparam logic [PollW-1:0]   POLL_RESET   = 27'd60000;
    localparam logic [StreakW-1:0] STREAK_MAX   = 3'd7;
    localparam logic [StreakW-1:0] AIR_SHIFT_MAX  = 3'd3;
    localparam logic [StreakW-1:0] HTTP_SHIFT_MAX = 3'd4;
    localparam logic [PollW-1:0]   LONG_CAP       = 27'd120000;
    localparam logic [PollW-1:0]   SHORT_CAP      = 27'd30000;
    localparam logic [PollW-1:0]   SHORT_BASE     = 27'd3000;
    localparam logic [PollW-1:0]   PREFLIGHT_WAIT = 27'd5000;
    localparam logic [PollW-1:0]   COOLDOWN_WAIT  = 27'd4000;

    localparam logic signed [StatusW-1:0] ST_TOO_MANY    = 11'sd429;
    localparam logic signed [StatusW-1:0] ST_UNAVAILABLE = 11'sd503;
    localparam logic signed [StatusW-1:0] ST_PREFLIGHT   = -11'sd2;
    localparam logic signed [StatusW-1:0] ST_COOLDOWN    = -11'sd3;

    typedef struct packed {
        logic               first_pending;
        logic               force_pending;
        logic [TimeW-1:0]   last_fetch;
        logic [TimeW-1:0]   next_due;
        logic [TimeW-1:0]   cooldown;
        logic [StreakW-1:0] streak;
    } fbs_state_t;

    // True when time a lies before time b, taking wrap into account.
    function automatic logic time_before(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
        logic [TimeW-1:0] d;
        d = a - b;
        return d[TimeW-1];
    endfunction

endpackage

FILE: rtl/fbs_backoff.sv
// Backoff length chosen on a failed fetch, by mode, status code and streak.
`timescale 1ns / 1ps

module fbs_backoff
    import fbs_pkg::*;
(
    input  logic [ModeW-1:0]          mode,
    input  logic [PollW-1:0]          poll,
    input  logic [StreakW-1:0]        streak,
    input  logic signed [StatusW-1:0] status,
    output logic [PollW-1:0]          backoff
);

    logic [StreakW-1:0] air_sh;
    logic [StreakW-1:0] http_sh;
    logic [PollW+2:0]   air_wide;
    logic [PollW+1:0]   thr_wide;
    logic [PollW-1:0]   http_wide;
    logic [PollW-1:0]   air_b;
    logic [PollW-1:0]   thr_b;
    logic [PollW-1:0]   http_b;
    logic               status_le0;
    logic               throttled;

    always_comb
    begin
        air_sh  = (streak > AIR_SHIFT_MAX) ? AIR_SHIFT_MAX : streak;
        http_sh = (streak > HTTP_SHIFT_MAX) ? HTTP_SHIFT_MAX : streak;

        air_wide = {3'b000, poll} << air_sh;
        air_b    = (air_wide > {3'b000, LONG_CAP}) ? LONG_CAP : air_wide[PollW-1:0];

        thr_wide = {poll, 2'b00};
        thr_b    = (thr_wide > {2'b00, LONG_CAP}) ? LONG_CAP : thr_wide[PollW-1:0];

        // The short base shifted by at most four stays far below the field width.
        http_wide = SHORT_BASE << http_sh;
        http_b    = (http_wide > SHORT_CAP) ? SHORT_CAP : http_wide;

        status_le0 = status[StatusW-1] || (status == '0);
        throttled  = (status == ST_TOO_MANY) || (status == ST_UNAVAILABLE);

        backoff = poll;
        if (mode == MODE_AIR)
        begin
            if (status_le0)
                backoff = air_b;
            else if (throttled)
                backoff = thr_b;
        end
        else
        begin
            if (status == ST_PREFLIGHT)
                backoff = PREFLIGHT_WAIT;
            else if (status == ST_COOLDOWN)
                backoff = COOLDOWN_WAIT;
            else if (status_le0)
                backoff = http_b;
            else if (throttled)
                backoff = thr_b;
        end
    end

endmodule

FILE: rtl/fbs_gate.sv
// Tick decision: whether a fetch is issued now, and the state a tick leaves.
`timescale 1ns / 1ps

module fbs_gate
    import fbs_pkg::*;
(
    input  fbs_state_t         cur,
    input  logic [ModeW-1:0]   mode,
    input  logic [PollW-1:0]   poll,
    input  logic               hold_en,
    input  logic [TimeW-1:0]   hold_until,
    input  logic [TimeW-1:0]   now,
    input  logic [JitterW-1:0] jitter,
    output logic               fetch,
    output fbs_state_t         nxt
);

    logic             hold_first;
    logic             cd_hold;
    logic [TimeW-1:0] due;
    logic [TimeW-1:0] since;

    always_comb
    begin
        hold_first = cur.first_pending && hold_en && time_before(now, hold_until);
        cd_hold    = (cur.cooldown != '0) && time_before(now, cur.cooldown);
        due        = (cur.next_due == '0) ? now : cur.next_due;
        since      = now - cur.last_fetch;
        nxt        = cur;
        fetch      = 1'b0;

        if (hold_first)
            fetch = 1'b0;
        else if (cur.force_pending)
            fetch = 1'b1;
        else if (mode == MODE_AIR)
        begin
            if (!cd_hold)
            begin
                // A zero due time is seeded with now even when no fetch follows.
                nxt.next_due = due;
                fetch = cur.first_pending || !time_before(now, due);
            end
        end
        else if (mode == MODE_HTTP && cd_hold)
            fetch = 1'b0;
        else
            fetch = cur.first_pending || (since >= {{(TimeW-PollW){1'b0}}, poll});

        if (fetch)
        begin
            nxt.last_fetch    = now;
            nxt.first_pending = 1'b0;
            nxt.force_pending = 1'b0;
            if (mode == MODE_AIR)
                nxt.next_due = now + {{(TimeW-PollW){1'b0}}, poll}
                                   + {{(TimeW-JitterW){1'b0}}, jitter};
        end
    end

endmodule

FILE: rtl/fetch_backoff_scheduler.sv
// Top level of the fetch backoff scheduler: item registers, state and handshakes.
`timescale 1ns / 1ps
// Path: an accepted item waits in the input register until the result register is empty or draining.
// Throughput: one item per cycle while the result side does not stall; the input register and the
// result register each hold one item, and the tick and backoff logic between them is combinational.
// Reset: asynchronous, active low; clears the valid flags of both item registers and the scheduler state,
// and puts the configuration registers at their documented reset values.

module fetch_backoff_scheduler
    import fbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // now_ms[31:0], fetch_ok[32], status_code[43:33], jitter_ms[59:44], zero fill
    input  logic [InDataW-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [CmdW-1:0]     s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // fetch_now[0], backoff_ms[27:1], failure_streak[30:28],
    // cooldown_until_ms[62:31], zero fill
    output logic [OutDataW-1:0] m_axis_tdata
);

    logic [ModeW-1:0]    mode_reg;
    logic [PollW-1:0]    poll_reg;
    logic                hold_en_reg;
    logic [TimeW-1:0]    hold_until_reg;

    logic                in_valid_reg;
    logic [InDataW-1:0]  in_data_reg;
    logic [CmdW-1:0]     in_cmd_reg;
    logic                out_valid_reg;
    logic [OutDataW-1:0] out_data_reg;
    logic [OutDataW-1:0] out_data_next;

    fbs_state_t          state_reg;
    fbs_state_t          state_next;
    fbs_state_t          tick_state;

    logic                fire;
    logic [TimeW-1:0]    now;
    logic                ok;
    logic signed [StatusW-1:0] status;
    logic [JitterW-1:0]  jitter;
    logic                tick_fetch;
    logic                fetch_now;
    logic [StreakW-1:0]  streak_inc;
    logic [PollW-1:0]    fail_backoff;
    logic [PollW-1:0]    backoff;

    assign now    = in_data_reg[31:0];
    assign ok     = in_data_reg[32];
    assign status = in_data_reg[43:33];
    assign jitter = in_data_reg[59:44];

    // The loaded item moves on whenever the result register is empty or draining.
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign streak_inc = (state_reg.streak == STREAK_MAX) ? STREAK_MAX
                                                         : state_reg.streak + 3'd1;

    fbs_gate u_gate (
        .cur        (state_reg),
        .mode       (mode_reg),
        .poll       (poll_reg),
        .hold_en    (hold_en_reg),
        .hold_until (hold_until_reg),
        .now        (now),
        .jitter     (jitter),
        .fetch      (tick_fetch),
        .nxt        (tick_state)
    );

    fbs_backoff u_backoff (
        .mode    (mode_reg),
        .poll    (poll_reg),
        .streak  (streak_inc),
        .status  (status),
        .backoff (fail_backoff)
    );

    always_comb
    begin
        state_next = state_reg;
        fetch_now  = 1'b0;
        backoff    = '0;
        case (in_cmd_reg)
            CMD_TICK:
            begin
                state_next = tick_state;
                fetch_now  = tick_fetch;
            end
            CMD_OUTCOME:
            begin
                // Plain polling modes ignore outcomes.
                if (!mode_reg[1])
                begin
                    if (ok)
                    begin
                        state_next.streak   = '0;
                        state_next.cooldown = '0;
                    end
                    else
                    begin
                        state_next.streak   = streak_inc;
                        state_next.cooldown = now + {{(TimeW-PollW){1'b0}}, fail_backoff};
                        backoff             = fail_backoff;
                    end
                end
            end
            CMD_FORCE:
                state_next.force_pending = 1'b1;
            default:
                state_next = state_reg;
        endcase
        out_data_next = {1'b0, state_next.cooldown, state_next.streak, backoff, fetch_now};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_POLL;
            poll_reg       <= POLL_RESET;
            hold_en_reg    <= 1'b0;
            hold_until_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_MODE: mode_reg       <= cfg_wdata[ModeW-1:0];
                REG_POLL:        poll_reg       <= cfg_wdata[PollW-1:0];
                REG_HOLD_EN:     hold_en_reg    <= cfg_wdata[0];
                REG_HOLD_UNTIL:  hold_until_reg <= cfg_wdata[TimeW-1:0];
                default:         hold_en_reg    <= hold_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{first_pending: 1'b1, force_pending: 1'b0,
                               last_fetch: '0, next_due: '0, cooldown: '0, streak: '0};
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_cmd_reg  <= s_axis_tuser;
        end
        if (fire)
            out_data_reg <= out_data_next;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !fire)
        else $error("result register overwritten while stalled");

    a_force_arms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_cmd_reg == CMD_FORCE |=> state_reg.force_pending)
        else $error("force item did not arm a fetch");

    a_fetch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && fetch_now |=> !state_reg.first_pending && !state_reg.force_pending)
        else $error("fetch left first or force pending");

    a_success_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_cmd_reg == CMD_OUTCOME && ok && !mode_reg[1]
        |=> state_reg.streak == '0 && state_reg.cooldown == '0)
        else $error("success did not clear streak and cooldown");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input not ready while input register is empty");

endmodule

FILE: bench/fbs_checker.sv
// Checker for the fetch backoff scheduler: tracks configuration, predicts each result and compares.
`timescale 1ns / 1ps

module fbs_checker
    import fbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    // now_ms[31:0], fetch_ok[32], status_code[43:33], jitter_ms[59:44], zero fill
    input  logic [InDataW-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [CmdW-1:0]     s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // fetch_now[0], backoff_ms[27:1], failure_streak[30:28],
    // cooldown_until_ms[62:31], zero fill
    input  logic [OutDataW-1:0] m_axis_tdata,
    output int                  mismatches,
    output int                  outstanding
);

    typedef struct packed {
        logic               fetch;
        logic [PollW-1:0]   backoff;
        logic [StreakW-1:0] streak;
        logic [TimeW-1:0]   cooldown;
    } sched_result_t;

    // Configuration copy.
    logic [ModeW-1:0]   mode_r;
    logic [PollW-1:0]   poll_r;
    logic               hold_en_r;
    logic [TimeW-1:0]   hold_until_r;

    // Scheduler state copy.
    logic               first_wait;
    logic               force_armed;
    logic [TimeW-1:0]   last_fetch_ms;
    logic [TimeW-1:0]   next_due_ms;
    logic [TimeW-1:0]   cooldown_ms;
    logic [StreakW-1:0] streak;

    sched_result_t result_q[$];

    function automatic logic earlier_than(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
        return $signed(a - b) < 0;
    endfunction

    function automatic logic take_tick(input logic [TimeW-1:0] now, input logic [JitterW-1:0] jit);
        logic [TimeW-1:0] since;
        since = now - last_fetch_ms;
        // The first-fetch hold wins even over a pending force.
        if (first_wait && hold_en_r && earlier_than(now, hold_until_r))
            return 1'b0;
        if (!force_armed)
        begin
            if (mode_r == MODE_AIR)
            begin
                if (cooldown_ms != '0 && earlier_than(now, cooldown_ms))
                    return 1'b0;
                if (next_due_ms == '0)
                    next_due_ms = now;
                if (!first_wait && earlier_than(now, next_due_ms))
                    return 1'b0;
            end
            else if (mode_r == MODE_HTTP && cooldown_ms != '0 && earlier_than(now, cooldown_ms))
                return 1'b0;
            else if (since < {5'd0, poll_r} && !first_wait)
                return 1'b0;
        end
        last_fetch_ms = now;
        if (mode_r == MODE_AIR)
            next_due_ms = now + {5'd0, poll_r} + {16'd0, jit};
        first_wait = 1'b0;
        force_armed = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [TimeW-1:0] throttle_ms();
        logic [TimeW-1:0] w;
        w = {5'd0, poll_r} << 2;
        return (w > LONG_CAP) ? {5'd0, LONG_CAP} : w;
    endfunction

    function automatic logic [PollW-1:0] take_outcome(input logic [TimeW-1:0] now, input logic ok,
                                                      input logic signed [StatusW-1:0] status);
        logic [TimeW-1:0]   wait_ms;
        logic [StreakW-1:0] shift;
        if (mode_r != MODE_AIR && mode_r != MODE_HTTP)
            return '0;
        if (ok)
        begin
            streak = '0;
            cooldown_ms = '0;
            return '0;
        end
        if (streak != STREAK_MAX)
            streak = streak + 1'b1;
        wait_ms = {5'd0, poll_r};
        if (mode_r == MODE_AIR)
        begin
            if (status <= 0)
            begin
                shift = (streak > AIR_SHIFT_MAX) ? AIR_SHIFT_MAX : streak;
                wait_ms = {5'd0, poll_r} << shift;
                if (wait_ms > LONG_CAP)
                    wait_ms = {5'd0, LONG_CAP};
            end
            else if (status == ST_TOO_MANY || status == ST_UNAVAILABLE)
                wait_ms = throttle_ms();
        end
        else
        begin
            if (status == ST_PREFLIGHT)
                wait_ms = {5'd0, PREFLIGHT_WAIT};
            else if (status == ST_COOLDOWN)
                wait_ms = {5'd0, COOLDOWN_WAIT};
            else if (status <= 0)
            begin
                shift = (streak > HTTP_SHIFT_MAX) ? HTTP_SHIFT_MAX : streak;
                wait_ms = {5'd0, SHORT_BASE} << shift;
                if (wait_ms > SHORT_CAP)
                    wait_ms = {5'd0, SHORT_CAP};
            end
            else if (status == ST_TOO_MANY || status == ST_UNAVAILABLE)
                wait_ms = throttle_ms();
        end
        // A cooldown end that wraps to zero reads as no cooldown at all.
        cooldown_ms = now + wait_ms;
        return wait_ms[PollW-1:0];
    endfunction

    function automatic sched_result_t schedule_item(input logic [CmdW-1:0] cmd,
                                                    input logic [InDataW-1:0] data);
        sched_result_t r;
        r.fetch = 1'b0;
        r.backoff = '0;
        case (cmd)
            CMD_TICK:    r.fetch = take_tick(data[31:0], data[59:44]);
            CMD_OUTCOME: r.backoff = take_outcome(data[31:0], data[32], data[43:33]);
            CMD_FORCE:   force_armed = 1'b1;
            default:     ;
        endcase
        r.streak = streak;
        r.cooldown = cooldown_ms;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [TimeW-1:0] want,
                                        input logic [TimeW-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        sched_result_t want;
        if (!rst_n)
        begin
            mode_r = MODE_POLL;
            poll_r = POLL_RESET;
            hold_en_r = 1'b0;
            hold_until_r = '0;
            first_wait = 1'b1;
            force_armed = 1'b0;
            last_fetch_ms = '0;
            next_due_ms = '0;
            cooldown_ms = '0;
            streak = '0;
            result_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOURCE_MODE: mode_r = cfg_wdata[ModeW-1:0];
                    REG_POLL:        poll_r = cfg_wdata[PollW-1:0];
                    REG_HOLD_EN:     hold_en_r = cfg_wdata[0];
                    REG_HOLD_UNTIL:  hold_until_r = cfg_wdata;
                    default:         ;
                endcase
            end
            // A result leaving now belongs to an item accepted at an earlier edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    $error("result with no item pending: %h", m_axis_tdata);
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("fetch_now", want.fetch, m_axis_tdata[0]);
                    check_field("backoff_ms", want.backoff, m_axis_tdata[27:1]);
                    check_field("failure_streak", want.streak, m_axis_tdata[30:28]);
                    check_field("cooldown_until_ms", want.cooldown, m_axis_tdata[62:31]);
                    check_field("zero fill", '0, m_axis_tdata[63]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                result_q.insert(result_q.size(), schedule_item(s_axis_tuser, s_axis_tdata));
            outstanding = result_q.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// Top of the fetch backoff scheduler bench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;
    import fbs_pkg::*;

    localparam logic [CmdW-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;
    localparam logic signed [StatusW-1:0] STATUS_MIN = 11'sh400;
    localparam logic signed [StatusW-1:0] STATUS_MAX = 11'sd1023;
    localparam int PHASE_ITEMS = 140;
    localparam int HOLD_CYCLES = 60;
    localparam int QUIET_LIMIT = 2000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic [CmdW-1:0]     s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int quiet_cycles = 0;
    logic [TimeW-1:0] clock_ms = '0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    fetch_backoff_scheduler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fbs_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Result side: random stalls, plus a long hold-off on request so the block backs up.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic offer(input logic [CmdW-1:0] cmd, input logic [TimeW-1:0] now,
                         input logic ok, input logic signed [StatusW-1:0] status,
                         input logic [JitterW-1:0] jitter);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata <= {4'd0, jitter, status, ok, now};
        s_axis_tuser <= cmd;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_config(input logic [ModeW-1:0] mode, input logic [PollW-1:0] poll,
                              input logic hold_en, input logic [TimeW-1:0] hold_until);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_SOURCE_MODE;
        cfg_wdata <= {30'd0, mode};
        @(negedge clk);
        cfg_index <= REG_POLL;
        cfg_wdata <= {5'd0, poll};
        @(negedge clk);
        cfg_index <= REG_HOLD_EN;
        cfg_wdata <= {31'd0, hold_en};
        @(negedge clk);
        cfg_index <= REG_HOLD_UNTIL;
        cfg_wdata <= hold_until;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Time mostly moves forward in steps scaled to the poll period, with rare jumps anywhere.
    task automatic offer_random(input logic [TimeW-1:0] stride);
        int unsigned pick;
        logic [CmdW-1:0] cmd;
        logic signed [StatusW-1:0] status;
        logic [JitterW-1:0] jitter;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, stride);
        if (pick < 55)
            cmd = CMD_TICK;
        else if (pick < 85)
            cmd = CMD_OUTCOME;
        else if (pick < 95)
            cmd = CMD_FORCE;
        else
            cmd = CMD_UNUSED;
        case ($urandom_range(0, 7))
            0:       status = ST_PREFLIGHT;
            1:       status = ST_COOLDOWN;
            2:       status = ST_TOO_MANY;
            3:       status = ST_UNAVAILABLE;
            4:       status = StatusW'($urandom);
            5:       status = -StatusW'($urandom_range(0, 1024));
            default: status = StatusW'($urandom_range(100, 599));
        endcase
        if ($urandom_range(0, 3) == 0)
            jitter = JitterW'($urandom);
        else
            jitter = JitterW'($urandom_range(0, 255));
        offer(cmd, clock_ms, $urandom_range(0, 2) == 0, status, jitter);
    endtask

    task automatic run_phase(input logic [ModeW-1:0] mode, input logic [PollW-1:0] poll,
                             input logic hold_en, input logic [TimeW-1:0] hold_until,
                             input logic [TimeW-1:0] stride, input int src_pct,
                             input int sink_pct, input logic pressure);
        set_config(mode, poll, hold_en, hold_until);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (pressure && i == PHASE_ITEMS / 2)
                hold_requests++;
            offer_random(stride);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Aircraft mode with the first-fetch hold armed.
        set_config(MODE_AIR, 27'd1000, 1'b1, 32'd5000);
        offer(CMD_TICK, 32'd0, 1'b0, 11'sd0, 16'd0);
        offer(CMD_FORCE, 32'd0, 1'b0, 11'sd0, 16'd0);
        // Still held by the first-fetch hold although a force is armed.
        offer(CMD_TICK, 32'd4999, 1'b0, 11'sd0, 16'd0);
        offer(CMD_TICK, 32'd5000, 1'b0, 11'sd0, 16'hFFFF);
        offer(CMD_TICK, 32'd6000, 1'b0, 11'sd0, 16'd0);
        offer(CMD_OUTCOME, 32'd6000, 1'b0, 11'sd0, 16'd0);
        offer(CMD_OUTCOME, 32'd6000, 1'b0, STATUS_MIN, 16'd0);
        offer(CMD_OUTCOME, 32'd6000, 1'b0, -11'sd1, 16'd0);
        offer(CMD_OUTCOME, 32'd6000, 1'b0, -11'sd1, 16'd0);
        offer(CMD_TICK, 32'd7000, 1'b0, 11'sd0, 16'd0);
        offer(CMD_OUTCOME, 32'd6000, 1'b0, ST_TOO_MANY, 16'd0);
        offer(CMD_OUTCOME, 32'd6000, 1'b0, ST_UNAVAILABLE, 16'd0);
        offer(CMD_OUTCOME, 32'd6000, 1'b0, STATUS_MAX, 16'd0);
        offer(CMD_OUTCOME, 32'd6000, 1'b1, 11'sd0, 16'd0);
        offer(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, STATUS_MAX, 16'hFFFF);

        // Generic HTTP rules; the first failure lands its cooldown end exactly on zero.
        set_config(MODE_HTTP, 27'd1000, 1'b0, 32'hFFFF_FFFF);
        offer(CMD_OUTCOME, 32'hFFFF_EC78, 1'b0, ST_PREFLIGHT, 16'd0);
        offer(CMD_OUTCOME, 32'd100, 1'b0, ST_COOLDOWN, 16'd0);
        offer(CMD_OUTCOME, 32'd100, 1'b0, 11'sd0, 16'd0);
        offer(CMD_OUTCOME, 32'd100, 1'b0, -11'sd5, 16'd0);
        offer(CMD_OUTCOME, 32'd100, 1'b0, ST_TOO_MANY, 16'd0);
        offer(CMD_OUTCOME, 32'd100, 1'b0, 11'sd200, 16'd0);
        offer(CMD_OUTCOME, 32'd100, 1'b0, 11'sd404, 16'd0);
        offer(CMD_OUTCOME, 32'd100, 1'b0, 11'sd500, 16'd0);
        offer(CMD_TICK, 32'd200, 1'b0, 11'sd0, 16'd0);
        offer(CMD_OUTCOME, 32'd300, 1'b1, 11'sd0, 16'd0);

        clock_ms = 32'd100000;
        run_phase(MODE_AIR, 27'd1000, 1'b0, 32'd0, 32'd600, 0, 0, 1'b1);
        run_phase(MODE_HTTP, 27'd500, 1'b1, 32'd0, 32'd300, 83, 0, 1'b0);
        run_phase(MODE_POLL, 27'd2000, 1'b0, 32'hFFFF_FFFF, 32'd1200, 0, 83, 1'b0);
        run_phase(MODE_SPARE, 27'd0, 1'b1, 32'h8000_0000, 32'd100, 10, 10, 1'b0);
        run_phase(MODE_AIR, 27'h7FF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'h0400_0000, 0, 0, 1'b1);
        run_phase(MODE_HTTP, 27'd86400000, 1'b0, 32'd0, 32'd50000000, 83, 0, 1'b0);
        run_phase(MODE_AIR, 27'd20000, 1'b0, 32'd0, 32'd12000, 0, 83, 1'b0);
        run_phase(MODE_HTTP, 27'd40000, 1'b0, 32'd0, 32'd25000, 10, 10, 1'b0);

        drain();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: fetch_backoff_scheduler.f
rtl/fbs_pkg.sv
rtl/fbs_backoff.sv
rtl/fbs_gate.sv
rtl/fetch_backoff_scheduler.sv
bench/fbs_checker.sv
bench/testbench.sv
